/* hdl/pngzw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngzw_pkg
// Shared types, byte script and CRC helper for the PNG stored-zlib writer.
// ----------------------------------------------------------------------------
package pngzw_pkg;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [31:0] BLOCK_MAX  = 32'd65535;
    localparam logic [6:0]  HDR_LAST   = 7'd75;
    localparam logic [6:0]  TRAIL_FIRST = 7'd76;
    localparam logic [6:0]  TRAIL_LAST = 7'd95;
    localparam logic [2:0]  BLKH_LAST  = 3'd4;

    // byte sources selected by the controller
    typedef enum logic [1:0] {
        SRC_SCRIPT = 2'd0,
        SRC_BLKH   = 2'd1,
        SRC_DATA   = 2'd2
    } src_t;

    // how a script byte is produced
    typedef enum logic [2:0] {
        SK_PLAIN    = 3'd0,
        SK_CRC      = 3'd1,
        SK_CRC_INIT = 3'd2,
        SK_WIDTH    = 3'd3,
        SK_HEIGHT   = 3'd4,
        SK_NCRC     = 3'd5,
        SK_LEN      = 3'd6,
        SK_ADLER    = 3'd7
    } skind_t;

    typedef struct packed {
        skind_t      kind;
        logic [1:0]  lane;
        logic [7:0]  value;
    } sentry_t;

    typedef struct packed {
        logic        accept;
        logic        calc_mul;
        logic        calc_blk;
        logic        calc_len;
        logic        byte_en;
        src_t        src;
        logic [6:0]  script_idx;
        logic [2:0]  blkh_idx;
        logic        data_filter;
        logic        flush;
    } cmd_t;

    typedef struct packed {
        logic first;
        logic col0;
        logic data;
        logic last;
        logic block_empty;
        logic can_issue;
        logic flush_ok;
    } status_t;

    // header (0..75) and trailer (76..95) constant bytes
    localparam logic [7:0] SCRIPT_ROM [96] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
        8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h04, 8'h03, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h15, 8'h50, 8'h4C, 8'h54, 8'h45,
        8'h39, 8'h30, 8'h39, 8'hFF, 8'hFF, 8'hFF, 8'h3A, 8'h5B, 8'h46,
        8'h3D, 8'h3B, 8'h5E, 8'h9C, 8'h48, 8'h4B, 8'hD0, 8'hBE, 8'h47,
        8'hB1, 8'h6A, 8'h49,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h49, 8'h44, 8'h41, 8'h54, 8'h78, 8'h01,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00,
        8'h49, 8'h45, 8'h4E, 8'h44,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    function automatic sentry_t script_entry(input logic [6:0] idx);
        sentry_t e;
        logic [1:0] base;
        e.value = SCRIPT_ROM[idx];
        base = 2'd0;
        case (idx) inside
            [7'd12:7'd12], [7'd37:7'd37],
            [7'd70:7'd70], [7'd88:7'd88]:  e.kind = SK_CRC_INIT;
            [7'd13:7'd15], [7'd24:7'd28], [7'd38:7'd61],
            [7'd71:7'd75], [7'd89:7'd91]:  e.kind = SK_CRC;
            [7'd16:7'd19]:                 e.kind = SK_WIDTH;
            [7'd20:7'd23]:                 e.kind = SK_HEIGHT;
            [7'd29:7'd32]:
            begin
                e.kind = SK_NCRC;
                base   = 2'd1;
            end
            [7'd62:7'd65], [7'd80:7'd83], [7'd92:7'd95]:
            begin
                e.kind = SK_NCRC;
                base   = (idx < 7'd70) ? 2'd2 : 2'd0;
            end
            [7'd66:7'd69]:
            begin
                e.kind = SK_LEN;
                base   = 2'd2;
            end
            [7'd76:7'd79]:                 e.kind = SK_ADLER;
            default:                       e.kind = SK_PLAIN;
        endcase
        e.lane = idx[1:0] - base;
        return e;
    endfunction

    function automatic logic [7:0] lane_byte(input logic [31:0] w, input logic [1:0] lane);
        logic [31:0] s;
        s = w >> (5'd8 * (5'd3 - {3'd0, lane}));
        return s[7:0];
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
        return r;
    endfunction

endpackage

/* hdl/pngzw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngzw_ctrl
// Sequencer: walks header, block headers, raw bytes, trailer and flush.
// ----------------------------------------------------------------------------
module pngzw_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pix_valid,
    output logic               pix_ready,
    input  pngzw_pkg::status_t st,
    output pngzw_pkg::cmd_t    cmd
);
    import pngzw_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_CALC1 = 11'b00000000100,
        S_CALC2 = 11'b00000001000,
        S_CALC3 = 11'b00000010000,
        S_HDR   = 11'b00000100000,
        S_RAW   = 11'b00001000000,
        S_BLKH  = 11'b00010000000,
        S_DATA  = 11'b00100000000,
        S_TRAIL = 11'b01000000000,
        S_FLUSH = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [6:0] idx_reg, idx_next;
    logic [2:0] sub_reg, sub_next;
    logic       pf_reg, pf_next;
    logic       pd_reg, pd_next;

    assign pix_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sub_next   = sub_reg;
        pf_next    = pf_reg;
        pd_next    = pd_reg;
        cmd        = '0;
        cmd.src        = SRC_SCRIPT;
        cmd.script_idx = idx_reg;
        cmd.blkh_idx   = sub_reg;
        cmd.data_filter = pf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pix_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                pf_next = st.col0;
                pd_next = st.data;
                if (st.first)
                    state_next = S_CALC1;
                else if (st.col0 || st.data)
                    state_next = S_RAW;
                else
                    state_next = S_FLUSH;
            end
            S_CALC1:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = S_CALC2;
            end
            S_CALC2:
            begin
                cmd.calc_blk = 1'b1;
                state_next   = S_CALC3;
            end
            S_CALC3:
            begin
                cmd.calc_len = 1'b1;
                idx_next     = '0;
                state_next   = S_HDR;
            end
            S_HDR, S_TRAIL:
            begin
                if (st.can_issue)
                begin
                    cmd.byte_en = 1'b1;
                    idx_next    = idx_reg + 7'd1;
                    if (idx_reg == HDR_LAST)
                        state_next = S_RAW;
                    else if (idx_reg == TRAIL_LAST)
                        state_next = S_FLUSH;
                end
            end
            S_RAW:
            begin
                sub_next   = '0;
                state_next = st.block_empty ? S_BLKH : S_DATA;
            end
            S_BLKH:
            begin
                cmd.src = SRC_BLKH;
                if (st.can_issue)
                begin
                    cmd.byte_en = 1'b1;
                    sub_next    = sub_reg + 3'd1;
                    if (sub_reg == BLKH_LAST)
                        state_next = S_DATA;
                end
            end
            S_DATA:
            begin
                cmd.src = SRC_DATA;
                if (st.can_issue)
                begin
                    cmd.byte_en = 1'b1;
                    if (pf_reg)
                        pf_next = 1'b0;
                    else
                        pd_next = 1'b0;
                    if (pf_reg && pd_reg)
                        state_next = S_RAW;
                    else if (st.last)
                    begin
                        idx_next   = TRAIL_FIRST;
                        state_next = S_TRAIL;
                    end
                    else
                        state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (st.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            sub_reg   <= '0;
            pf_reg    <= 1'b0;
            pd_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sub_reg   <= sub_next;
            pf_reg    <= pf_next;
            pd_reg    <= pd_next;
        end
    end

endmodule

/* hdl/pngzw_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pngzw_dpath
// Datapath: config, raster counters, CRC/Adler, block counts, word packer.
// ----------------------------------------------------------------------------
module pngzw_dpath #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_sel,
    input  logic [12:0]        cfg_value,
    input  logic [3:0]         pixel,
    input  pngzw_pkg::cmd_t    cmd,
    output pngzw_pkg::status_t st,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        out_bytes,
    output logic [2:0]         byte_count,
    output logic               run_last,
    output logic               image_end
);
    import pngzw_pkg::*;

    localparam int     WB      = $clog2(MAX_WIDTH + 1);
    localparam int     HB      = $clog2(MAX_HEIGHT + 1);
    localparam longint RAW_MAX = longint'(MAX_HEIGHT) * longint'((MAX_WIDTH + 1) / 2 + 1);
    localparam int     RB      = $clog2(RAW_MAX + 1);

    logic [12:0]   wcfg_reg, hcfg_reg;
    logic [WB-1:0] uw, col_reg;
    logic [HB-1:0] uh, row_reg;
    logic [16:0]   w17, h17;
    logic          col_last, row_last;

    logic [3:0]    held_reg;
    logic [7:0]    pix_byte_reg;
    logic          f_first_reg, f_col0_reg, f_data_reg, f_last_reg;

    logic [31:0]   crc_reg;
    logic [15:0]   alo_reg, ahi_reg;
    logic [15:0]   blk_left_reg;
    logic [RB-1:0] raw_left_reg;
    logic [16:0]   blocks_reg;
    logic [31:0]   idat_len_reg;

    logic [31:0]   acc_reg;
    logic [2:0]    acc_cnt_reg;
    logic          ov_reg, ol_reg, oe_reg;
    logic [31:0]   ob_reg;
    logic [2:0]    oc_reg;

    // clamp configured size
    assign w17 = {4'd0, wcfg_reg};
    assign h17 = {4'd0, hcfg_reg};
    assign uw  = (w17 == 17'd0) ? WB'(1) : (w17 > 17'(MAX_WIDTH))  ? WB'(MAX_WIDTH)  : WB'(w17);
    assign uh  = (h17 == 17'd0) ? HB'(1) : (h17 > 17'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(h17);
    assign col_last = (col_reg == uw - WB'(1));
    assign row_last = (row_reg == uh - HB'(1));

    // block length and byte selection
    logic [31:0] raw32;
    logic [15:0] blk_len;
    sentry_t     se;
    logic [7:0]  bval;
    logic        crc_upd, crc_init;

    assign raw32   = 32'(raw_left_reg);
    assign blk_len = (raw32 > BLOCK_MAX) ? 16'hFFFF : raw32[15:0];
    assign se      = script_entry(cmd.script_idx);

    always_comb
    begin
        bval     = se.value;
        crc_upd  = 1'b1;
        crc_init = 1'b0;
        case (cmd.src)
            SRC_SCRIPT:
            begin
                case (se.kind)
                    SK_PLAIN:    crc_upd = 1'b0;
                    SK_CRC_INIT: crc_init = 1'b1;
                    SK_WIDTH:    bval = lane_byte(32'(uw), se.lane);
                    SK_HEIGHT:   bval = lane_byte(32'(uh), se.lane);
                    SK_NCRC:
                    begin
                        bval    = lane_byte(~crc_reg, se.lane);
                        crc_upd = 1'b0;
                    end
                    SK_LEN:
                    begin
                        bval    = lane_byte(idat_len_reg, se.lane);
                        crc_upd = 1'b0;
                    end
                    SK_ADLER:    bval = lane_byte({ahi_reg, alo_reg}, se.lane);
                    default:     bval = se.value;
                endcase
            end
            SRC_BLKH:
            begin
                case (cmd.blkh_idx)
                    3'd0:    bval = (raw32 <= BLOCK_MAX) ? 8'd1 : 8'd0;
                    3'd1:    bval = blk_len[7:0];
                    3'd2:    bval = blk_len[15:8];
                    3'd3:    bval = ~blk_len[7:0];
                    default: bval = ~blk_len[15:8];
                endcase
            end
            default: bval = cmd.data_filter ? 8'd0 : pix_byte_reg;
        endcase
    end

    // Adler-32 step
    logic [16:0] alo_sum, ahi_sum;
    logic [15:0] alo_new, ahi_new;
    assign alo_sum = {1'b0, alo_reg} + {9'd0, bval};
    assign alo_new = (alo_sum >= ADLER_MOD) ? 16'(alo_sum - ADLER_MOD) : alo_sum[15:0];
    assign ahi_sum = {1'b0, ahi_reg} + {1'b0, alo_new};
    assign ahi_new = (ahi_sum >= ADLER_MOD) ? 16'(ahi_sum - ADLER_MOD) : ahi_sum[15:0];

    // block count: raw / 65535 rounded up, via 2^16 = 65535 + 1
    logic [16:0] q0, rem0, rem1, q1, q2;
    assign q0   = {1'b0, raw32[31:16]};
    assign rem0 = {1'b0, raw32[15:0]} + q0;
    assign q1   = (rem0 >= 17'd131070) ? q0 + 17'd2 : (rem0 >= 17'd65535) ? q0 + 17'd1 : q0;
    assign rem1 = (rem0 >= 17'd131070) ? rem0 - 17'd131070 :
                  (rem0 >= 17'd65535)  ? rem0 - 17'd65535 : rem0;
    assign q2   = q1 + {16'd0, (rem1 != 17'd0)};

    // packer
    logic out_free, push_full, push_flush;
    assign out_free   = !ov_reg || out_ready;
    assign push_full  = cmd.byte_en && (acc_cnt_reg == 3'd4);
    assign push_flush = cmd.flush && (acc_cnt_reg != 3'd0);

    assign st.first       = f_first_reg;
    assign st.col0        = f_col0_reg;
    assign st.data        = f_data_reg;
    assign st.last        = f_last_reg;
    assign st.block_empty = (blk_left_reg == 16'd0);
    assign st.can_issue   = (acc_cnt_reg != 3'd4) || out_free;
    assign st.flush_ok    = (acc_cnt_reg == 3'd0) || out_free;

    assign out_valid  = ov_reg;
    assign out_bytes  = ob_reg;
    assign byte_count = oc_reg;
    assign run_last   = ol_reg;
    assign image_end  = oe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wcfg_reg    <= 13'd1;
            hcfg_reg    <= 13'd1;
            col_reg     <= '0;
            row_reg     <= '0;
            f_first_reg <= 1'b0;
            f_col0_reg  <= 1'b0;
            f_data_reg  <= 1'b0;
            f_last_reg  <= 1'b0;
            crc_reg     <= '1;
            alo_reg     <= 16'd1;
            ahi_reg     <= 16'd0;
            blk_left_reg <= '0;
            raw_left_reg <= '0;
            acc_cnt_reg <= '0;
            acc_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel)
                    hcfg_reg <= cfg_value;
                else
                    wcfg_reg <= cfg_value;
                col_reg <= '0;
                row_reg <= '0;
            end
            if (cmd.accept)
            begin
                f_first_reg <= (col_reg == '0) && (row_reg == '0);
                f_col0_reg  <= (col_reg == '0);
                f_data_reg  <= col_reg[0] || col_last;
                f_last_reg  <= col_last && row_last;
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_last ? '0 : row_reg + HB'(1);
                end
                else
                    col_reg <= col_reg + WB'(1);
            end
            if (cmd.calc_mul)
            begin
                raw_left_reg <= RB'(uh * ((WB+1)'(uw) + (WB+1)'(1) >> 1) + RB'(uh));
                blk_left_reg <= '0;
                alo_reg      <= 16'd1;
                ahi_reg      <= 16'd0;
            end
            if (cmd.byte_en)
            begin
                if (crc_upd)
                    crc_reg <= crc_byte(crc_init ? '1 : crc_reg, bval);
                if (cmd.src == SRC_BLKH && cmd.blkh_idx == BLKH_LAST)
                    blk_left_reg <= blk_len;
                if (cmd.src == SRC_DATA)
                begin
                    alo_reg <= alo_new;
                    ahi_reg <= ahi_new;
                    if (blk_left_reg != '0)
                        blk_left_reg <= blk_left_reg - 16'd1;
                    if (raw_left_reg != '0)
                        raw_left_reg <= raw_left_reg - RB'(1);
                end
                if (push_full)
                begin
                    acc_reg     <= {bval, 24'd0};
                    acc_cnt_reg <= 3'd1;
                end
                else
                begin
                    acc_reg     <= acc_reg | ({bval, 24'd0} >> (6'd8 * {3'd0, acc_cnt_reg}));
                    acc_cnt_reg <= acc_cnt_reg + 3'd1;
                end
            end
            else if (cmd.flush)
            begin
                acc_reg     <= '0;
                acc_cnt_reg <= '0;
            end
            if (push_full || push_flush)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_byte_reg <= col_reg[0] ? {held_reg, pixel} : {pixel, 4'd0};
            if (!col_reg[0])
                held_reg <= pixel;
        end
        if (cmd.calc_blk)
            blocks_reg <= q2;
        if (cmd.calc_len)
            idat_len_reg <= raw32 + {13'd0, blocks_reg, 2'd0} + {15'd0, blocks_reg} + 32'd6;
        if (push_full || push_flush)
        begin
            ob_reg <= acc_reg;
            oc_reg <= acc_cnt_reg;
            ol_reg <= push_flush;
            oe_reg <= push_flush && f_last_reg;
        end
    end

endmodule

/* hdl/png_stored_zlib_writer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_stored_zlib_writer_unit
// PNG writer for 4-bit palette pixels using stored (uncompressed) deflate.
// ----------------------------------------------------------------------------
// One 4-bit palette pixel per input transfer, raster order. The block emits
// a full PNG stream: on the first pixel of a frame the signature, IHDR,
// a fixed 7-color PLTE, the IDAT length/type and zlib header; per row a
// filter byte 0 and pixels packed two per byte (high nibble first); stored
// deflate blocks of up to 65535 bytes; on the last pixel the Adler-32, IDAT
// CRC and IEND. Output transfers carry up to four bytes, first byte in
// bits 31..24; tlast marks the last transfer caused by a pixel, tuser the
// transfer holding the final IEND byte. Pixels are handled one at a time;
// a pixel that only holds its nibble goes straight to the flush; a pixel
// that emits one payload byte (filter or pixel byte), or a row-start pixel
// that emits both, passes a select state and an issue state per payload
// byte. A stored block header adds the issue of its 5 bytes; the first
// pixel of a frame adds the size multiply, block count, IDAT length and
// 76 header bytes, and the last pixel adds the 20 trailer bytes.
// An output register decouples the stream; a stalled output halts bytes
// only once the packing word is full. Config writes rearm the frame and must
// only be issued while idle.
// ----------------------------------------------------------------------------
module png_stored_zlib_writer_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    // pixel stream in; tdata: pixel[3:0], zero pad [7:4]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // byte stream out; tdata: out_bytes[31:0], byte_count[34:32], pad [39:35]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,
    output logic        m_axis_tlast,   // run_last
    output logic        m_axis_tuser,   // image_end
    // config write: index 0 width, 1 height
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import pngzw_pkg::*;

    cmd_t        cmd;
    status_t     st;
    logic [31:0] out_bytes;
    logic [2:0]  byte_count;

    // config always taken; caller only writes while idle
    assign cfg_ready = 1'b1;

    pngzw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (s_axis_tvalid),
        .pix_ready (s_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    pngzw_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_sel    (cfg_index),
        .cfg_value  (cfg_data),
        .pixel      (s_axis_tdata[3:0]),
        .cmd        (cmd),
        .st         (st),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_bytes  (out_bytes),
        .byte_count (byte_count),
        .run_last   (m_axis_tlast),
        .image_end  (m_axis_tuser)
    );

    assign m_axis_tdata = {5'd0, byte_count, out_bytes};

endmodule
